FILE: sv/kscp_pkg.sv
package kscp_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  localparam int unsigned ACC_W  = 36;   // Horner accumulator width
  localparam int unsigned FOV_W  = 18;
  localparam int unsigned T_W    = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;    // capture the request fields
    logic       wr_key;      // write the table entry
    logic       add_time;    // saturating elapsed += delta
    logic       rd_last;     // read the last entry
    logic       rd_next;     // read entry cur+1 for the search
    logic       step_cur;    // cur <= cur + 1
    logic       clr_cur;     // cur <= 0
    logic       clr_time;    // elapsed <= 0
    logic       rd_pt;       // read point j (0..3) of the segment
    logic [1:0] pt_sel;
    logic       div_start;
    logic       hor_start;
    logic       out_last;    // load the result with the last key
    logic       out_fin;     // load the result from the spline
  } kscp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;      // elapsed >= time of last key
    logic next_le;     // cur+1 < n and time[cur+1] <= elapsed
    logic cur_ge_n;
    logic div_busy;
    logic hor_busy;
  } kscp_sts_t;

endpackage

FILE: sv/kscp_ctrl.sv
module kscp_ctrl import kscp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic       n_ok,
  input  kscp_sts_t  sts,
  input  logic       out_busy,
  output kscp_cmd_t  cmd,
  output logic       out_load
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_RLAST = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_PTS   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_HOR   = 10'b0010000000,
    S_WAIT  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] pt_r, pt_nxt;
  logic       playing_r, playing_nxt;
  logic       fin_r, fin_nxt;
  mode_t      mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pt_r      <= '0;
      playing_r <= 1'b0;
      fin_r     <= 1'b0;
      mode_r    <= MODE_WRITE;
    end else begin
      state_r   <= state_nxt;
      pt_r      <= pt_nxt;
      playing_r <= playing_nxt;
      fin_r     <= fin_nxt;
      if (in_valid && !in_stall) mode_r <= mode_t'(in_mode);
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    pt_nxt      = pt_r;
    playing_nxt = playing_r;
    fin_nxt     = fin_r;
    cmd         = '0;
    cmd.pt_sel  = pt_r;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (mode_r)
          MODE_WRITE: cmd.wr_key = 1'b1;
          MODE_START: playing_nxt = 1'b1;
          MODE_STOP: begin
            playing_nxt  = 1'b0;
            cmd.clr_cur  = 1'b1;
            cmd.clr_time = 1'b1;
          end
          default: begin
            if (playing_r && n_ok) begin
              cmd.add_time = 1'b1;
              state_nxt    = S_RLAST;
            end
          end
        endcase
      end
      S_RLAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (sts.at_end) begin
          cmd.out_last = 1'b1;
          cmd.clr_cur  = 1'b1;
          cmd.clr_time = 1'b1;
          playing_nxt  = 1'b0;
          fin_nxt      = 1'b1;
          state_nxt    = S_WAIT;
        end else begin
          if (sts.cur_ge_n) cmd.clr_cur = 1'b1;
          fin_nxt   = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // Each search step: read time[cur+1], then compare.
        if (pt_r == 2'd0) begin
          cmd.rd_next = 1'b1;
          pt_nxt      = 2'd1;
        end else if (sts.next_le) begin
          cmd.step_cur = 1'b1;
          pt_nxt       = 2'd0;
        end else begin
          pt_nxt    = 2'd0;
          state_nxt = S_PTS;
        end
      end
      S_PTS: begin
        cmd.rd_pt = 1'b1;
        pt_nxt    = pt_r + 2'd1;
        if (pt_r == 2'd3) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_HOR;
      end
      S_HOR: begin
        if (!sts.div_busy) begin
          cmd.hor_start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.hor_busy) begin
          if (!fin_r) cmd.out_fin = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/kscp_dp.sv
module kscp_dp import kscp_pkg::*; #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kscp_cmd_t           cmd,
  output kscp_sts_t           sts,
  output logic                n_ok,
  input  logic [6:0]          key_count,
  input  logic [5:0]          in_key_index,
  input  logic [31:0]         in_key_time,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_look_x,
  input  logic signed [31:0]  in_look_y,
  input  logic signed [31:0]  in_look_z,
  input  logic [FOV_W-1:0]    in_key_fov,
  input  logic [15:0]         in_delta_time,
  output logic signed [31:0]  res_v [6],
  output logic [FOV_W-1:0]    res_fov
);

  localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);
  localparam int unsigned EW = 6 * 32 + FOV_W;

  // One memory row per key: six coordinates and the fov; times apart.
  logic [EW-1:0] key_mem [MAX_KEYS];
  logic [31:0]   time_mem [MAX_KEYS];

  logic [5:0]          idx_r;
  logic [31:0]         ktime_r;
  logic [EW-1:0]       kdata_r;
  logic [15:0]         delta_r;
  logic [31:0]         elapsed_r;
  logic [IW-1:0]       cur_r;
  logic [31:0]         trd_r;
  logic [EW-1:0]       rd_r;
  logic [EW-1:0]       pts_r [4];
  logic [31:0]         t1_r, t2_r;
  logic [1:0]          pt_d_r;
  logic                rdpt_d_r;

  logic [NW-1:0] n_sat;
  logic [NW:0]   cur1, cur2;
  logic [IW-1:0] last_i, rd_idx;
  logic [32:0]   esum;

  assign n_sat  = ({25'd0, key_count} > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign n_ok   = (n_sat >= NW'(2));
  assign last_i = IW'(n_sat - NW'(1));
  assign cur1   = (NW+1)'(cur_r) + (NW+1)'(1);
  assign cur2   = (NW+1)'(cur_r) + (NW+1)'(2);
  assign esum   = {1'b0, elapsed_r} + 33'(delta_r);

  always_comb begin
    rd_idx = cur_r;
    case (cmd.pt_sel)
      2'd0: rd_idx = (cur_r == '0) ? '0 : cur_r - IW'(1);
      2'd1: rd_idx = cur_r;
      2'd2: rd_idx = (cur1 < (NW+1)'(n_sat)) ? IW'(cur1) : last_i;
      default: rd_idx = (cur2 < (NW+1)'(n_sat)) ? IW'(cur2) : last_i;
    endcase
    if (cmd.rd_last) rd_idx = last_i;
    if (cmd.rd_next) rd_idx = IW'(cur1);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key && ({26'd0, idx_r} < 32'(MAX_KEYS))) begin
      key_mem[IW'(idx_r)]  <= kdata_r;
      time_mem[IW'(idx_r)] <= ktime_r;
    end
    trd_r <= time_mem[rd_idx];
    rd_r  <= key_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      cur_r     <= '0;
      rdpt_d_r  <= 1'b0;
    end else begin
      rdpt_d_r <= cmd.rd_pt;
      if (cmd.add_time) elapsed_r <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
      if (cmd.clr_time) elapsed_r <= '0;
      if (cmd.step_cur) cur_r <= IW'(cur1);
      if (cmd.clr_cur)  cur_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      idx_r   <= in_key_index;
      ktime_r <= in_key_time;
      kdata_r <= {in_pos_x, in_pos_y, in_pos_z, in_look_x, in_look_y, in_look_z,
                  in_key_fov};
      delta_r <= in_delta_time;
    end
    pt_d_r <= cmd.pt_sel;
    if (rdpt_d_r) begin
      pts_r[pt_d_r] <= rd_r;
      if (pt_d_r == 2'd1) t1_r <= trd_r;
      if (pt_d_r == 2'd2) t2_r <= trd_r;
    end
  end

  assign sts.at_end   = (elapsed_r >= trd_r);
  assign sts.next_le  = (cur1 < (NW+1)'(n_sat)) && (trd_r <= elapsed_r);
  assign sts.cur_ge_n = ((NW+1)'(cur_r) >= (NW+1)'(n_sat));

  // Fraction t by restoring division.
  logic        div_busy;
  logic [T_W-1:0] t_q;
  kscp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .t1    (t1_r),
    .t2    (t2_r),
    .el    (elapsed_r),
    .busy  (div_busy),
    .t_q   (t_q)
  );
  assign sts.div_busy = div_busy;

  logic signed [31:0] sv [6];
  logic               hor_busy;
  logic [FOV_W-1:0]   fov_q;
  kscp_spl u_spl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hor_start),
    .t     (t_q),
    .p0    (pts_r[0]),
    .p1    (pts_r[1]),
    .p2    (pts_r[2]),
    .p3    (pts_r[3]),
    .busy  (hor_busy),
    .v     (sv),
    .fov   (fov_q)
  );
  assign sts.hor_busy = hor_busy;

  always_ff @(posedge clk) begin
    if (cmd.out_last) begin
      for (int k = 0; k < 6; k++) res_v[k] <= rd_r[EW-1-32*k -: 32];
      res_fov <= rd_r[FOV_W-1:0];
    end else if (cmd.out_fin) begin
      for (int k = 0; k < 6; k++) res_v[k] <= sv[k];
      res_fov <= fov_q;
    end
  end

endmodule

FILE: sv/kscp_div.sv
module kscp_div import kscp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [31:0]    t1,
  input  logic [31:0]    t2,
  input  logic [31:0]    el,
  output logic           busy,
  output logic [T_W-1:0] t_q
);

  // Quotient of ((el-t1)<<16)/(t2-t1), one bit a cycle, saturated to 16 bits.
  logic [32:0]    rem_r;
  logic [31:0]    den_r;
  logic [47:0]    num_r;
  logic [16:0]    q_r;
  logic [5:0]     cnt_r;
  logic           zero_r;
  logic [33:0]    trial;

  assign trial = {rem_r, num_r[47]} - {2'b0, den_r};
  assign busy  = (cnt_r != '0);
  assign t_q   = zero_r ? '0 : (q_r[16] ? 16'hFFFF : q_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd48;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      den_r  <= t2 - t1;
      num_r  <= {el - t1, 16'd0};
      q_r    <= '0;
      zero_r <= !((t2 > t1) && (el > t1));
    end else if (busy) begin
      num_r <= {num_r[46:0], 1'b0};
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        q_r   <= (q_r[16] ? q_r : {q_r[15:0], 1'b1}) | {q_r[16] | q_r[15], 16'd0};
      end else begin
        rem_r <= {rem_r[31:0], num_r[47]};
        q_r   <= q_r[16] ? q_r : {q_r[15:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/kscp_spl.sv
module kscp_spl import kscp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [T_W-1:0]        t,
  input  logic [6*32+FOV_W-1:0] p0,
  input  logic [6*32+FOV_W-1:0] p1,
  input  logic [6*32+FOV_W-1:0] p2,
  input  logic [6*32+FOV_W-1:0] p3,
  output logic                  busy,
  output logic signed [31:0]    v [6],
  output logic [FOV_W-1:0]      fov
);

  localparam int unsigned EW = 6 * 32 + FOV_W;

  // One shared multiplier: per channel 3 Horner steps, each a multiply
  // phase then an accumulate phase. Channel 6 is the fov lerp.
  logic [2:0]              ch_r;
  logic [2:0]              step_r;
  logic                    ph_r;
  logic                    run_r;
  logic signed [ACC_W-1:0] s_r;
  logic signed [ACC_W+17:0] prod_r;
  logic signed [ACC_W-1:0] a0, a1, a2, a3, c_co, b_co, a_co, pp1;
  logic signed [ACC_W-1:0] addend, nxt;
  logic signed [ACC_W+17:0] fl;

  always_comb begin
    a0 = ACC_W'(signed'(p0[EW-1-32*ch_r -: 32]));
    a1 = ACC_W'(signed'(p1[EW-1-32*ch_r -: 32]));
    a2 = ACC_W'(signed'(p2[EW-1-32*ch_r -: 32]));
    a3 = ACC_W'(signed'(p3[EW-1-32*ch_r -: 32]));
    c_co = -a0 + 3 * a1 - 3 * a2 + a3;
    b_co = 2 * a0 - 5 * a1 + 4 * a2 - a3;
    a_co = a2 - a0;
    pp1  = 2 * a1;
    case (step_r)
      3'd0: addend = b_co;
      3'd1: addend = a_co;
      default: addend = pp1;
    endcase
    fl  = prod_r >>> 16;
    nxt = addend + ACC_W'(fl);
  end

  assign busy = run_r;

  logic signed [ACC_W-1:0] sh;
  logic signed [ACC_W-1:0] fv1, fv2;
  assign sh  = nxt >>> 1;
  assign fv1 = ACC_W'({1'b0, p1[FOV_W-1:0]});
  assign fv2 = ACC_W'({1'b0, p2[FOV_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (run_r && ph_r && ch_r == 3'd6) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r   <= '0;
      step_r <= '0;
      ph_r   <= 1'b0;
      s_r    <= '0;
    end else if (run_r) begin
      if (!ph_r) begin
        if (ch_r == 3'd6) prod_r <= (ACC_W+18)'(fv2 - fv1) * $signed({2'b0, t});
        else prod_r <= (step_r == 3'd0 ? c_co : s_r) * $signed({2'b0, t});
        ph_r <= 1'b1;
      end else begin
        ph_r <= 1'b0;
        if (ch_r == 3'd6) begin
          fov <= FOV_W'(fv1 + ACC_W'(fl));
        end else if (step_r == 3'd2) begin
          if (sh > ACC_W'(signed'(32'h7FFF_FFFF)))      v[ch_r] <= 32'h7FFF_FFFF;
          else if (sh < ACC_W'(signed'(32'h8000_0000))) v[ch_r] <= 32'h8000_0000;
          else v[ch_r] <= sh[31:0];
          step_r <= '0;
          ch_r   <= ch_r + 3'd1;
        end else begin
          s_r    <= nxt;
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

endmodule

FILE: sv/keyframe_spline_camera_player.sv
// Channel   | Direction | Handshake          | Payload
// in_*      | input     | in_valid/in_stall  | mode, key fields, delta_time
// out_*     | output    | out_valid/out_stall| position, look-at, fov, finished
// cfg_*     | input     | cfg_we             | key_count
//
// A write, start or stop request, or a tick when stopped or under two keys,
// passes through dispatch and back to idle; a tick that runs past the last key
// reads the last key, checks the end and emits that key. Any other tick runs the
// dispatch, the end check, the search, the four segment reads, the bit-serial
// divider, the shared spline multiplier and the result load. Reset clears play,
// elapsed time and index; the table is not cleared. The result is held in a
// register until out_stall drops, and a stalled output holds the tick in emit.
module keyframe_spline_camera_player import kscp_pkg::*; #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_key_count,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_look_x,
  input  logic signed [31:0] in_look_y,
  input  logic signed [31:0] in_look_z,
  input  logic [17:0]        in_key_fov,
  input  logic [15:0]        in_delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_look_x,
  output logic signed [31:0] out_look_y,
  output logic signed [31:0] out_look_z,
  output logic [17:0]        out_fov,
  output logic               out_finished
);

  // Write the key count register only while idle; the block does not enforce it.
  logic [6:0] key_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_we) begin
      key_count_r <= cfg_key_count;
    end
  end

  kscp_cmd_t cmd;
  kscp_sts_t sts;
  logic      n_ok;
  logic      out_load;
  logic signed [31:0] res_v [6];
  logic [FOV_W-1:0]   res_fov;

  kscp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .n_ok     (n_ok),
    .sts      (sts),
    .out_busy (out_valid && out_stall),
    .cmd      (cmd),
    .out_load (out_load)
  );

  kscp_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .n_ok          (n_ok),
    .key_count     (key_count_r),
    .in_key_index  (in_key_index),
    .in_key_time   (in_key_time),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_look_x     (in_look_x),
    .in_look_y     (in_look_y),
    .in_look_z     (in_look_z),
    .in_key_fov    (in_key_fov),
    .in_delta_time (in_delta_time),
    .res_v         (res_v),
    .res_fov       (res_fov)
  );

  // Output register: loaded when the previous result has been taken.
  logic fin_sel_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      fin_sel_r <= 1'b0;
    end else begin
      if (cmd.out_last) fin_sel_r <= 1'b1;
      else if (cmd.out_fin) fin_sel_r <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x    <= res_v[0];
      out_pos_y    <= res_v[1];
      out_pos_z    <= res_v[2];
      out_look_x   <= res_v[3];
      out_look_y   <= res_v[4];
      out_look_z   <= res_v[5];
      out_fov      <= res_fov;
      out_finished <= fin_sel_r;
    end
  end

endmodule
